FILE: hw/rtl/nearest_waypoint_haversine_macros.svh
// Assertion macros for the nearest waypoint block
`ifndef NEAREST_WAYPOINT_HAVERSINE_MACROS_SVH
`define NEAREST_WAYPOINT_HAVERSINE_MACROS_SVH

// Check cons in the cycle after ante
`define NWH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the same cycle as ante
`define NWH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nwh_pkg.sv
// Shared types, constants and tables of the nearest waypoint block
`default_nettype none

package nwh_pkg;

  localparam int MAX_WAYPOINTS = 1024;
  localparam int CORDIC_STEPS  = 24;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 22;
  localparam int NIDX_W = 10;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

  localparam int CW     = 36;
  localparam int MW     = 34;
  localparam int PW     = 68;
  localparam int STEP_W = 5;
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;
  localparam int A_W    = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LON = 2'd1;

  localparam logic signed [CW-1:0] DEG90        = 36'sd1509949440;
  localparam logic signed [CW-1:0] DEG180       = 36'sd3019898880;
  localparam logic signed [CW-1:0] ONE_Q30      = 36'sd1073741824;
  localparam logic signed [CW-1:0] CORDIC_START = 36'sd652032874;
  localparam logic signed [MW-1:0] DEG_TO_RAD   = 34'sd18740330;
  localparam logic signed [MW-1:0] DIST_SCALE   = 34'sd2076128051;

  localparam logic signed [PW-1:0] RND23 = PW'(64'd1 << 23);
  localparam logic signed [PW-1:0] RND29 = PW'(64'd1 << 29);
  localparam logic signed [PW-1:0] RND39 = PW'(64'd1 << 39);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] k);
    logic signed [CW-1:0] r;
    case (k)
      5'd0:  r = 36'sh03243F6A8;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFC;
      5'd3:  r = 36'sh007F56EA6;
      5'd4:  r = 36'sh003FEAB76;
      5'd5:  r = 36'sh001FFD55B;
      5'd6:  r = 36'sh000FFFAAA;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEA;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      5'd24: r = 36'sh00000003F;
      5'd25: r = 36'sh00000001F;
      5'd26: r = 36'sh00000000F;
      5'd27: r = 36'sh000000007;
      5'd28: r = 36'sh000000003;
      5'd29: r = 36'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nwh_point_if.sv
// Waypoint input channel
`default_nettype none

interface nwh_point_if import nwh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] point_lat;
  logic signed [LON_W-1:0] point_lon;
  logic                    last_point;

  modport source(output valid, point_lat, point_lon, last_point, input ready);
  modport sink(input valid, point_lat, point_lon, last_point, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nwh_result_if.sv
// Nearest waypoint result channel
`default_nettype none

interface nwh_result_if import nwh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NIDX_W-1:0] nearest_index;
  logic [DIST_W-1:0] nearest_distance;
  logic              too_many;

  modport source(output valid, nearest_index, nearest_distance, too_many, input ready);
  modport sink(input valid, nearest_index, nearest_distance, too_many, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nwh_cordic.sv
// Shared CORDIC unit, rotation or vectoring mode, one step per cycle
`default_nettype none

module nwh_cordic import nwh_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cordic_ctl_t          ctl_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] z_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [CW-1:0]      z_o,
  output logic                      done_o
);

  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [CW-1:0] sx, sy, at;
  logic [STEP_W-1:0]    k_q;
  logic                 run_q, vec_q, done_q, pos;

  always_comb begin
    sx  = x_q >>> k_q;
    sy  = y_q >>> k_q;
    at  = atan_q30(k_q);
    pos = vec_q ? (y_q <= 0) : (z_q >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      vec_q  <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        vec_q <= ctl_i.vec;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + STEP_W'(1);
        if (k_q == STEP_W'(CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (run_q) begin
      if (pos) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + at;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/nwh_isqrt.sv
// Integer square root, computed one result bit at a time
`default_nettype none

module nwh_isqrt import nwh_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SQ_W-1:0]   n_i,
  output logic [ROOT_W-1:0]      root_o,
  output logic                   done_o
);

  logic [SQ_W-1:0]   rem_q, res_q, bit_v, trial;
  logic [STEP_W-1:0] i_q;
  logic              run_q, done_q;

  always_comb begin
    bit_v = SQ_W'(1) << {i_q, 1'b0};
    trial = res_q + bit_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= STEP_W'(ROOT_W - 1);
      end else if (run_q) begin
        i_q <= i_q - STEP_W'(1);
        if (i_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= n_i;
      res_q <= '0;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_v;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign root_o = res_q[ROOT_W-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/nwh_dist.sv
// Haversine distance sequencer around a shared multiplier, CORDIC and square root
`default_nettype none

module nwh_dist import nwh_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [LAT_W-1:0] lat1_i,
  input  wire logic signed [LON_W-1:0] lon1_i,
  input  wire logic signed [LAT_W-1:0] lat2_i,
  input  wire logic signed [LON_W-1:0] lon2_i,
  output logic [DIST_W-1:0]            dist_o,
  output logic                         done_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_REDUCE, ST_FOLD, ST_MUL, ST_RAD, ST_CWAIT, ST_SQ,
    ST_CC, ST_AST, ST_SQRT1, ST_SQRT2, ST_VWAIT, ST_FIN
  } state_e;

  typedef enum logic [1:0] {JOB_HS, JOB_HO, JOB_C1, JOB_C2} job_e;

  state_e state_q, ret_q;
  job_e   job_q;

  logic signed [LAT_W-1:0] lat1_q, lat2_q;
  logic signed [LON_W-1:0] lon1_q, lon2_q;
  logic signed [CW-1:0]    acc_q, hs_q, ho_q, c1_q, yr_q;
  logic signed [CW-1:0]    cx_q, cy_q, cz_q;
  logic signed [MW-1:0]    mul_a_q, mul_b_q;
  logic signed [PW-1:0]    prod_q;
  logic [A_W-1:0]          a_q;
  logic [SQ_W-1:0]         sq_n_q;
  logic                    sq_start_q, neg_q, done_q;
  logic [DIST_W-1:0]       dist_q;
  cordic_ctl_t             cctl_q;

  logic signed [CW-1:0] cx, cy, cz, fold_v, rnd30, cosv, a_v, zpos;
  logic signed [PW-1:0] dscale;
  logic                 fold_neg, sine_job, cdone, sq_done;
  logic [ROOT_W-1:0]    root;

  nwh_cordic u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl_q), .x_i(cx_q), .y_i(cy_q), .z_i(cz_q),
    .x_o(cx), .y_o(cy), .z_o(cz), .done_o(cdone)
  );

  nwh_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start_q), .n_i(sq_n_q), .root_o(root), .done_o(sq_done)
  );

  always_comb begin
    sine_job = (job_q == JOB_HS) || (job_q == JOB_HO);
    fold_v   = acc_q;
    fold_neg = 1'b0;
    if (sine_job) begin
      if (acc_q >= DEG90) fold_v = acc_q - DEG180;
    end else if (acc_q > DEG90) begin
      fold_v   = DEG180 - acc_q;
      fold_neg = 1'b1;
    end else if (acc_q < -DEG90) begin
      fold_v   = -DEG180 - acc_q;
      fold_neg = 1'b1;
    end
    rnd30  = CW'((prod_q + RND29) >>> 30);
    cosv   = neg_q ? -cx : cx;
    a_v    = hs_q + rnd30;
    zpos   = (cz < 0) ? '0 : cz;
    dscale = (prod_q + RND39) >>> 40;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ret_q      <= ST_IDLE;
      job_q      <= JOB_HS;
      cctl_q     <= '0;
      sq_start_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      cctl_q.start <= 1'b0;
      sq_start_q   <= 1'b0;
      done_q       <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            lat1_q  <= lat1_i;
            lon1_q  <= lon1_i;
            lat2_q  <= lat2_i;
            lon2_q  <= lon2_i;
            job_q   <= JOB_HS;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          unique case (job_q)
            JOB_HS: begin
              acc_q   <= CW'(lat2_q) - CW'(lat1_q);
              state_q <= ST_REDUCE;
            end
            JOB_HO: begin
              acc_q   <= CW'(lon2_q) - CW'(lon1_q);
              state_q <= ST_REDUCE;
            end
            JOB_C1: begin
              acc_q   <= CW'(lat1_q) <<< 1;
              state_q <= ST_FOLD;
            end
            default: begin
              acc_q   <= CW'(lat2_q) <<< 1;
              state_q <= ST_FOLD;
            end
          endcase
        end
        ST_REDUCE: begin
          if (acc_q < 0) acc_q <= acc_q + DEG180;
          else if (acc_q >= DEG180) acc_q <= acc_q - DEG180;
          else state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          neg_q   <= fold_neg;
          mul_a_q <= MW'(fold_v);
          mul_b_q <= DEG_TO_RAD;
          ret_q   <= ST_RAD;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= mul_a_q * mul_b_q;
          state_q <= ret_q;
        end
        ST_RAD: begin
          cx_q         <= CORDIC_START;
          cy_q         <= '0;
          cz_q         <= CW'((prod_q + RND23) >>> 24);
          cctl_q.start <= 1'b1;
          cctl_q.vec   <= 1'b0;
          state_q      <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (cdone) begin
            unique case (job_q)
              JOB_HS, JOB_HO: begin
                mul_a_q <= MW'(cy);
                mul_b_q <= MW'(cy);
                ret_q   <= ST_SQ;
                state_q <= ST_MUL;
              end
              JOB_C1: begin
                c1_q    <= cosv;
                job_q   <= JOB_C2;
                state_q <= ST_PREP;
              end
              default: begin
                mul_a_q <= MW'(c1_q);
                mul_b_q <= MW'(cosv);
                ret_q   <= ST_CC;
                state_q <= ST_MUL;
              end
            endcase
          end
        end
        ST_SQ: begin
          if (job_q == JOB_HS) begin
            hs_q  <= rnd30;
            job_q <= JOB_HO;
          end else begin
            ho_q  <= rnd30;
            job_q <= JOB_C1;
          end
          state_q <= ST_PREP;
        end
        ST_CC: begin
          mul_a_q <= MW'(rnd30);
          mul_b_q <= MW'(ho_q);
          ret_q   <= ST_AST;
          state_q <= ST_MUL;
        end
        ST_AST: begin
          if (a_v < 0) begin
            a_q    <= '0;
            sq_n_q <= '0;
          end else if (a_v > ONE_Q30) begin
            a_q    <= A_W'(ONE_Q30);
            sq_n_q <= SQ_W'(ONE_Q30) << 30;
          end else begin
            a_q    <= A_W'(a_v);
            sq_n_q <= SQ_W'(a_v) << 30;
          end
          sq_start_q <= 1'b1;
          state_q    <= ST_SQRT1;
        end
        ST_SQRT1: begin
          if (sq_done) begin
            yr_q       <= CW'(root);
            sq_n_q     <= (SQ_W'(ONE_Q30) - SQ_W'(a_q)) << 30;
            sq_start_q <= 1'b1;
            state_q    <= ST_SQRT2;
          end
        end
        ST_SQRT2: begin
          if (sq_done) begin
            cx_q         <= CW'(root);
            cy_q         <= yr_q;
            cz_q         <= '0;
            cctl_q.start <= 1'b1;
            cctl_q.vec   <= 1'b1;
            state_q      <= ST_VWAIT;
          end
        end
        ST_VWAIT: begin
          if (cdone) begin
            mul_a_q <= MW'(zpos);
            mul_b_q <= DIST_SCALE;
            ret_q   <= ST_FIN;
            state_q <= ST_MUL;
          end
        end
        ST_FIN: begin
          dist_q  <= (dscale > PW'(DIST_MAX)) ? DIST_MAX : DIST_W'(dscale);
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign dist_o = dist_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/nearest_waypoint_haversine.sv
// Top level of the nearest waypoint search by haversine distance
`default_nettype none
`include "nearest_waypoint_haversine_macros.svh"

// Takes one waypoint at a time and computes its great-circle distance to the
// target set through the configuration port (index 0 latitude, 1 longitude,
// degrees times 2^23). For each waypoint the shared CORDIC runs four rotation
// passes and one vectoring pass of CORDIC_STEPS steps, the square root unit two
// passes of 31 steps, a shared multiplier sits between them, and the two
// differences pass through an angle reduction. Ready is low while a waypoint
// is in work. On the last-marked waypoint one result word gives the
// lowest-index nearest waypoint, its distance in 1/256 mile and the overflow
// flag, and the search restarts.
// A finished result waits in an output register while the next waypoint runs.

module nearest_waypoint_haversine import nwh_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  nwh_point_if.sink                 point_in,
  nwh_result_if.source              result_out
);

  logic signed [LAT_W-1:0] target_lat_q, lat_q;
  logic signed [LON_W-1:0] target_lon_q, lon_q;
  logic                    last_q, busy_q, start_q, pend_q, out_valid_q;
  logic [DIST_W-1:0]       d_q, best_dist_q, best_dist_d, out_dist_q, pt_dist;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    ovf_q, ovf_d, out_ovf_q, dist_done;
  logic [NIDX_W-1:0]       out_idx_q;
  logic                    accept, update;

  nwh_dist u_dist (
    .clk_i, .rst_ni, .start_i(start_q),
    .lat1_i(lat_q), .lon1_i(lon_q), .lat2_i(target_lat_q), .lon2_i(target_lon_q),
    .dist_o(pt_dist), .done_o(dist_done)
  );

  assign point_in.ready = !busy_q;
  assign accept = point_in.valid && point_in.ready;
  assign update = pend_q && (!last_q || !out_valid_q || result_out.ready);

  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    if (cnt_q < CNT_W'(MAX_WAYPOINTS)) begin
      if (d_q < best_dist_q) begin
        best_dist_d = d_q;
        best_idx_d  = cnt_q[IDX_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_lat_q <= '0;
      target_lon_q <= '0;
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      best_dist_q  <= DIST_MAX;
      best_idx_q   <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TARGET_LAT: target_lat_q <= cfg_data_i[LAT_W-1:0];
          CFG_TARGET_LON: target_lon_q <= cfg_data_i[LON_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy_q  <= 1'b1;
        start_q <= 1'b1;
      end
      if (dist_done) pend_q <= 1'b1;
      if (result_out.valid && result_out.ready) out_valid_q <= 1'b0;
      if (update) begin
        pend_q <= 1'b0;
        busy_q <= 1'b0;
        if (last_q) begin
          out_valid_q <= 1'b1;
          best_dist_q <= DIST_MAX;
          best_idx_q  <= '0;
          cnt_q       <= '0;
          ovf_q       <= 1'b0;
        end else begin
          best_dist_q <= best_dist_d;
          best_idx_q  <= best_idx_d;
          cnt_q       <= cnt_d;
          ovf_q       <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_q  <= point_in.point_lat;
      lon_q  <= point_in.point_lon;
      last_q <= point_in.last_point;
    end
    if (dist_done) d_q <= pt_dist;
    if (update && last_q) begin
      out_idx_q  <= NIDX_W'(best_idx_d);
      out_dist_q <= best_dist_d;
      out_ovf_q  <= ovf_d;
    end
  end

  assign result_out.valid            = out_valid_q;
  assign result_out.nearest_index    = out_idx_q;
  assign result_out.nearest_distance = out_dist_q;
  assign result_out.too_many         = out_ovf_q;

  `NWH_ASSERT_NEXT(a_busy_after_accept, accept, !point_in.ready, "ready high during work")
  `NWH_ASSERT_SAME(a_done_while_busy, dist_done, busy_q && !pend_q, "distance without waypoint")
  `NWH_ASSERT_SAME(a_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_WAYPOINTS), "count past limit")

endmodule

`default_nettype wire
